@@ src/umx_pkg.sv @@
// Shared types and constants for the universal machine execute core.
// Used by umx_ctrl, umx_dp and universal_machine_execute_core.
package umx_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned RegAw    = 3;
  localparam int unsigned NumRegs  = 1 << RegAw;
  localparam int unsigned KindW    = 4;
  localparam int unsigned OpcW     = 4;
  localparam int unsigned ImmW     = 25;
  localparam int unsigned DivCntW  = $clog2(WordW);
  localparam int unsigned InTdataW  = 72;   // 67 payload bits padded to bytes
  localparam int unsigned OutTdataW = 104;  // 99 payload bits padded to bytes

  // instruction opcodes (bits 31..28)
  localparam logic [OpcW-1:0] OPC_CMOV     = 4'd0;
  localparam logic [OpcW-1:0] OPC_INDEX    = 4'd1;
  localparam logic [OpcW-1:0] OPC_AMEND    = 4'd2;
  localparam logic [OpcW-1:0] OPC_ADD      = 4'd3;
  localparam logic [OpcW-1:0] OPC_MUL      = 4'd4;
  localparam logic [OpcW-1:0] OPC_DIV      = 4'd5;
  localparam logic [OpcW-1:0] OPC_NAND     = 4'd6;
  localparam logic [OpcW-1:0] OPC_HALT     = 4'd7;
  localparam logic [OpcW-1:0] OPC_ALLOC    = 4'd8;
  localparam logic [OpcW-1:0] OPC_FREE     = 4'd9;
  localparam logic [OpcW-1:0] OPC_OUTPUT   = 4'd10;
  localparam logic [OpcW-1:0] OPC_INPUT    = 4'd11;
  localparam logic [OpcW-1:0] OPC_LOADPROG = 4'd12;
  localparam logic [OpcW-1:0] OPC_IMM      = 4'd13;

  // request kinds
  localparam logic [KindW-1:0] KIND_DONE     = 4'd0;
  localparam logic [KindW-1:0] KIND_READ     = 4'd1;
  localparam logic [KindW-1:0] KIND_WRITE    = 4'd2;
  localparam logic [KindW-1:0] KIND_ALLOC    = 4'd3;
  localparam logic [KindW-1:0] KIND_FREE     = 4'd4;
  localparam logic [KindW-1:0] KIND_OUTPUT   = 4'd5;
  localparam logic [KindW-1:0] KIND_INPUT    = 4'd6;
  localparam logic [KindW-1:0] KIND_LOADPROG = 4'd7;
  localparam logic [KindW-1:0] KIND_HALT     = 4'd8;
  localparam logic [KindW-1:0] KIND_FAULT    = 4'd9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_BC,
    ST_RD_A,
    ST_EXEC,
    ST_MUL_WB,
    ST_DIV,
    ST_DIV_WB,
    ST_EMIT
  } umx_state_t;

  typedef struct packed {
    logic load_in;   // capture input transaction
    logic rd_bc;     // read registers B and C
    logic rd_a;      // read register A
    logic exec;      // decode, write back simple ops, capture result
    logic mul_wb;    // write product
    logic div_step;  // one quotient bit
    logic div_wb;    // write quotient
    logic out_load;  // move result into output register
  } umx_cmd_t;

  typedef struct packed {
    logic exec_mul;  // instruction in EXEC is a multiply
    logic exec_div;  // instruction in EXEC is a divide by nonzero
    logic div_last;  // last divider step this cycle
  } umx_sts_t;

endpackage

@@ src/umx_ctrl.sv @@
// Controller state machine of the execute core: sequences read, execute,
// multiply/divide write-back and result hand-off. Depends on umx_pkg.
module umx_ctrl import umx_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  umx_sts_t sts,
  output umx_cmd_t cmd
);

  umx_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_RD_BC;
        end
      end
      ST_RD_BC: begin
        cmd.rd_bc = 1'b1;
        state_nxt = ST_RD_A;
      end
      ST_RD_A: begin
        cmd.rd_a  = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        priority if (sts.exec_mul) begin
          state_nxt = ST_MUL_WB;
        end else if (sts.exec_div) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_MUL_WB: begin
        cmd.mul_wb = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_DIV_WB;
        end
      end
      ST_DIV_WB: begin
        cmd.div_wb = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

@@ src/umx_dp.sv @@
// Datapath of the execute core: register file, decode, multiplier,
// radix-2 restoring divider, result and output registers. Depends on umx_pkg.
module umx_dp import umx_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  umx_cmd_t          cmd,
  output umx_sts_t          sts,
  input  logic              in_operation,
  input  logic [WordW-1:0]  in_instruction_word,
  input  logic [WordW-1:0]  in_return_value,
  input  logic [RegAw-1:0]  in_return_reg,
  output logic [KindW-1:0]  out_request_kind,
  output logic [RegAw-1:0]  out_target_reg,
  output logic [WordW-1:0]  out_first_arg,
  output logic [WordW-1:0]  out_second_arg,
  output logic [WordW-1:0]  out_third_arg
);

  // captured transaction
  logic              op_r;
  logic [WordW-1:0]  word_r;
  logic [WordW-1:0]  retval_r;
  logic [RegAw-1:0]  retreg_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r     <= in_operation;
      word_r   <= in_instruction_word;
      retval_r <= in_return_value;
      retreg_r <= in_return_reg;
    end
  end

  logic [OpcW-1:0]  opc;
  logic [RegAw-1:0] ra, rb, rc, imm_ra;
  logic [ImmW-1:0]  imm;

  assign opc    = word_r[WordW-1 -: OpcW];
  assign imm_ra = word_r[ImmW +: RegAw];
  assign imm    = word_r[ImmW-1:0];
  assign ra     = word_r[2*RegAw +: RegAw];
  assign rb     = word_r[RegAw +: RegAw];
  assign rc     = word_r[RegAw-1:0];

  // register file: two read ports, one write port; unwritten entries read zero
  logic [WordW-1:0]   mem [NumRegs];
  logic [NumRegs-1:0] vld_r;
  logic [WordW-1:0]   va_r, vb_r, vc_r;
  logic               wr_en;
  logic [RegAw-1:0]   wr_addr;
  logic [WordW-1:0]   wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_bc) begin
      vb_r <= vld_r[rb] ? mem[rb] : '0;
      vc_r <= vld_r[rc] ? mem[rc] : '0;
    end
    if (cmd.rd_a) begin
      va_r <= vld_r[ra] ? mem[ra] : '0;
    end
  end

  // decode and simple ops
  logic [KindW-1:0] kind;
  logic [RegAw-1:0] tgt;
  logic [WordW-1:0] a1, a2, a3;
  logic             ex_we;
  logic [RegAw-1:0] ex_waddr;
  logic [WordW-1:0] ex_wdata;
  logic             is_mul, is_div;

  always_comb begin
    kind     = KIND_DONE;
    tgt      = '0;
    a1       = '0;
    a2       = '0;
    a3       = '0;
    ex_we    = 1'b0;
    ex_waddr = ra;
    ex_wdata = '0;
    is_mul   = 1'b0;
    is_div   = 1'b0;
    if (op_r) begin
      ex_we    = 1'b1;
      ex_waddr = retreg_r;
      ex_wdata = retval_r;
    end else begin
      unique case (opc)
        OPC_CMOV: begin
          ex_we    = (vc_r != '0);
          ex_wdata = vb_r;
        end
        OPC_INDEX: begin
          kind = KIND_READ;
          tgt  = ra;
          a1   = vb_r;
          a2   = vc_r;
        end
        OPC_AMEND: begin
          kind = KIND_WRITE;
          a1   = va_r;
          a2   = vb_r;
          a3   = vc_r;
        end
        OPC_ADD: begin
          ex_we    = 1'b1;
          ex_wdata = vb_r + vc_r;
        end
        OPC_MUL: is_mul = 1'b1;
        OPC_DIV: begin
          if (vc_r == '0) begin
            kind = KIND_FAULT;
          end else begin
            is_div = 1'b1;
          end
        end
        OPC_NAND: begin
          ex_we    = 1'b1;
          ex_wdata = ~(vb_r & vc_r);
        end
        OPC_HALT: kind = KIND_HALT;
        OPC_ALLOC: begin
          kind = KIND_ALLOC;
          tgt  = rb;
          a1   = vc_r;
        end
        OPC_FREE: begin
          kind = KIND_FREE;
          a1   = vc_r;
        end
        OPC_OUTPUT: begin
          kind = KIND_OUTPUT;
          a1   = {{(WordW-8){1'b0}}, vc_r[7:0]};
        end
        OPC_INPUT: begin
          kind = KIND_INPUT;
          tgt  = rc;
        end
        OPC_LOADPROG: begin
          kind = KIND_LOADPROG;
          a1   = vb_r;
          a2   = vc_r;
        end
        OPC_IMM: begin
          ex_we    = 1'b1;
          ex_waddr = imm_ra;
          ex_wdata = {{(WordW-ImmW){1'b0}}, imm};
        end
        default: kind = KIND_FAULT;
      endcase
    end
  end

  // multiplier: low word only, registered before write-back
  logic [WordW-1:0] prod_lo;
  logic [WordW-1:0] prod_r;

  assign prod_lo = vb_r * vc_r;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      prod_r <= prod_lo;
    end
  end

  // restoring divider, one quotient bit per cycle; divisor held in vc_r
  logic [WordW-1:0]   quo_r, rem_r;
  logic [DivCntW-1:0] cnt_r;
  logic [WordW:0]     trial;

  assign trial = {rem_r, quo_r[WordW-1]} - {1'b0, vc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.exec) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      quo_r <= vb_r;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      if (!trial[WordW]) begin
        rem_r <= trial[WordW-1:0];
        quo_r <= {quo_r[WordW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[WordW-2:0], quo_r[WordW-1]};
        quo_r <= {quo_r[WordW-2:0], 1'b0};
      end
    end
  end

  // write port select
  always_comb begin
    wr_en   = (cmd.exec & ex_we) | cmd.mul_wb | cmd.div_wb;
    wr_addr = cmd.exec ? ex_waddr : ra;
    priority if (cmd.exec) begin
      wr_data = ex_wdata;
    end else if (cmd.mul_wb) begin
      wr_data = prod_r;
    end else begin
      wr_data = quo_r;
    end
  end

  assign sts.exec_mul = is_mul;
  assign sts.exec_div = is_div;
  assign sts.div_last = (cnt_r == DivCntW'(WordW-1));

  // result staging and output registers
  logic [KindW-1:0] res_kind_r, out_kind_r;
  logic [RegAw-1:0] res_tgt_r, out_tgt_r;
  logic [WordW-1:0] res_a1_r, res_a2_r, res_a3_r;
  logic [WordW-1:0] out_a1_r, out_a2_r, out_a3_r;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_kind_r <= kind;
      res_tgt_r  <= tgt;
      res_a1_r   <= a1;
      res_a2_r   <= a2;
      res_a3_r   <= a3;
    end
    if (cmd.out_load) begin
      out_kind_r <= res_kind_r;
      out_tgt_r  <= res_tgt_r;
      out_a1_r   <= res_a1_r;
      out_a2_r   <= res_a2_r;
      out_a3_r   <= res_a3_r;
    end
  end

  assign out_request_kind = out_kind_r;
  assign out_target_reg   = out_tgt_r;
  assign out_first_arg    = out_a1_r;
  assign out_second_arg   = out_a2_r;
  assign out_third_arg    = out_a3_r;

endmodule

@@ src/universal_machine_execute_core.sv @@
// Top level of the universal machine execute core: stream ports, packing,
// controller and datapath. Depends on umx_pkg, umx_ctrl and umx_dp.
//
// Usage:
//   The input stream carries one operation per transaction: tuser selects
//   execute (0) or write-back of a returned value (1). Every input
//   transaction gives exactly one result transaction on the output stream;
//   tuser there holds the request kind (done, read, write, alloc, free,
//   output, input, loadprog, halt, fault) and tdata the target register and
//   arguments for the outside memory, allocator and terminal.
//   One item at a time: in_tready is high only while the controller idles.
//   After accept the controller reads B and C, then A, and executes; a
//   multiply then writes its product back, and a divide runs its loop (one
//   quotient bit per cycle over 32 bits), which sets the worst case, and
//   writes its quotient back. Each item then loads its result for output.
//   The output register lets the next item be accepted and executed while a
//   result is stalled; the core then waits before loading its own result.
//   Reset (rst_n low, synchronous) makes the eight machine registers read
//   as zero and empties the output register.
module universal_machine_execute_core import umx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // [31:0] instruction_word, [63:32] return_value, [66:64] return_reg
  input  logic [InTdataW-1:0]  in_tdata,
  // [0] operation
  input  logic [0:0]           in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [2:0] target_reg, [34:3] first_arg, [66:35] second_arg, [98:67] third_arg
  output logic [OutTdataW-1:0] out_tdata,
  // [3:0] request_kind
  output logic [KindW-1:0]     out_tuser
);

  umx_cmd_t         cmd;
  umx_sts_t         sts;
  logic [RegAw-1:0] tgt;
  logic [WordW-1:0] a1, a2, a3;

  umx_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  umx_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_operation        (in_tuser[0]),
    .in_instruction_word (in_tdata[WordW-1:0]),
    .in_return_value     (in_tdata[2*WordW-1:WordW]),
    .in_return_reg       (in_tdata[2*WordW +: RegAw]),
    .out_request_kind    (out_tuser),
    .out_target_reg      (tgt),
    .out_first_arg       (a1),
    .out_second_arg      (a2),
    .out_third_arg       (a3)
  );

  assign out_tdata = {{(OutTdataW-RegAw-3*WordW){1'b0}}, a3, a2, a1, tgt};

endmodule
